>>> design/abws_pkg.sv
// shared constants and types for the boost and wane sum block
package abws_pkg;
    localparam int MaxExposures  = 64;
    localparam int NumAntigens   = 64;
    localparam int NumBiomarkers = 64;
    localparam int MapDepth      = NumAntigens * NumBiomarkers;
    localparam int ExpIdxW       = $clog2(MaxExposures);
    localparam int ExpCntW       = $clog2(MaxExposures + 1);
    localparam int MapAddrW      = $clog2(MapDepth);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_MAPWR  = 2'd2,
        OP_QUERY  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_LONG_GAIN   = 3'd0,
        CFG_SHORT_GAIN  = 3'd1,
        CFG_WANE_RATE   = 3'd2,
        CFG_SEN_RATE    = 3'd3,
        CFG_STRICT      = 3'd4,
        CFG_ANTIGEN_CNT = 3'd5
    } t_cfg_idx;

    // one exposure as it moves along the chain of cells
    typedef struct packed {
        logic        valid;
        logic [15:0] dt;
        logic [16:0] long_val;
        logic [16:0] short_val;
        logic [6:0]  n;
        logic        last;
    } t_tok;
endpackage

>>> design/abws_cell.sv
// one arithmetic cell of the chain: registered stage of the per-exposure term
module abws_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_kind,
    input  logic [23:0]        i_long_gain,
    input  logic [23:0]        i_short_gain,
    input  logic [15:0]        i_wane_rate,
    input  logic [15:0]        i_sen_rate,
    input  abws_pkg::t_tok     i_tok,
    input  logic [47:0]        i_a,
    input  logic [47:0]        i_b,
    input  logic [47:0]        i_c,
    output abws_pkg::t_tok     o_tok,
    output logic [47:0]        o_a,
    output logic [47:0]        o_b,
    output logic [47:0]        o_c
);
    // kind 0: products of gains, and wane/seniority factors clamped at zero
    // kind 1: shift long boost, short boost times wane
    // kind 2: add long boost and shifted short term
    // kind 3: sum times seniority
    logic [47:0] n_a, n_b, n_c;
    logic [32:0] w_prod, s_prod;

    always_comb begin
        n_a = i_a;
        n_b = i_b;
        n_c = i_c;
        w_prod = '0;
        s_prod = '0;
        case (i_kind)
            3'd0: begin
                n_a = 48'(i_long_gain) * 48'(i_tok.long_val);
                n_b = 48'(i_short_gain) * 48'(i_tok.short_val);
                w_prod = 33'(i_wane_rate) * 33'(i_tok.dt);
                s_prod = 33'(i_sen_rate) * 33'(i_tok.n - 7'd1);
                n_c = {14'd0, w_prod[32] | (|w_prod[31:16]) ? 17'd0 : 17'h10000 - 17'(w_prod[15:0]),
                       s_prod[32] | (|s_prod[31:16]) ? 17'd0 : 17'h10000 - 17'(s_prod[15:0])};
            end
            3'd1: begin
                n_a = {16'd0, i_a[47:16]};
                n_b = 48'(i_b[47:16]) * 48'(i_c[33:17]);
                n_c = i_c;
            end
            3'd2: begin
                n_a = 48'(i_a[31:0]) + 48'(i_b[47:16]);
                n_b = '0;
                n_c = i_c;
            end
            3'd3: begin
                n_a = 48'(i_a[33:0]) * 48'(i_c[16:0]);
                n_b = '0;
                n_c = '0;
            end
            default: begin
                n_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tok.valid <= 1'b0;
        end else begin
            o_tok.valid <= i_tok.valid;
        end
        o_tok.dt        <= i_tok.dt;
        o_tok.long_val  <= i_tok.long_val;
        o_tok.short_val <= i_tok.short_val;
        o_tok.n         <= i_tok.n;
        o_tok.last      <= i_tok.last;
        o_a <= n_a;
        o_b <= n_b;
        o_c <= n_c;
    end
endmodule

>>> design/antibody_boost_wane_sum.sv
// top level: exposure list, maps, walk sequencer, cell chain and accumulator
//
// usage: raise i_start with i_opcode and the fields for one transaction while
// o_busy is low. clear, append and map-write transactions complete while idle
// and give no result. a query walks the stored exposures one per cycle from
// the exposure memory, reads both maps for each, and pushes the exposure
// through a chain of four arithmetic cells (gain products and clamps, wane
// product, add, seniority product) feeding an accumulator.
// o_busy stays high until the result is given, so a new query is not taken
// before the previous one has finished.
// o_valid is high for one cycle with o_predicted_level and
// o_infections_counted; the receiver cannot stall it.
// the user writes configuration via i_cfg_we, i_cfg_idx, i_cfg_data while idle; the block never checks.
// reset sets the configuration to defaults, clears the control registers and the exposure count; maps and exposure
// memory hold no reset value and must be written before use.
module antibody_boost_wane_sum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_exposure_time,
    input  logic [5:0]  i_exposure_antigen,
    input  logic [11:0] i_map_address,
    input  logic [16:0] i_map_long_value,
    input  logic [16:0] i_map_short_value,
    input  logic [15:0] i_sample_time,
    input  logic [5:0]  i_biomarker_index,
    input  logic signed [31:0] i_base_level,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    output logic        o_valid,
    output logic signed [31:0] o_predicted_level,
    output logic [6:0]  o_infections_counted
);
    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_DONE} t_state;

    localparam int ExpIdxW  = abws_pkg::ExpIdxW;
    localparam int ExpCntW  = abws_pkg::ExpCntW;
    localparam int MapAddrW = abws_pkg::MapAddrW;

    logic [23:0] r_long_gain, r_short_gain;
    logic [15:0] r_wane_rate, r_sen_rate;
    logic        r_strict;
    logic [6:0]  r_antigen_cnt;

    logic [15:0] r_exp_time [abws_pkg::MaxExposures];
    logic [5:0]  r_exp_ant  [abws_pkg::MaxExposures];
    logic [16:0] r_long_map  [abws_pkg::MapDepth];
    logic [16:0] r_short_map [abws_pkg::MapDepth];
    logic [ExpCntW-1:0] r_total;

    t_state r_state;
    logic [ExpCntW-1:0] r_idx;
    logic [15:0] r_st;
    logic [5:0]  r_bio;
    logic signed [33:0] r_acc;
    logic [6:0]  r_n;

    // stage 1: exposure memory read
    logic        r_s1_valid, r_s1_last;
    logic [15:0] r_s1_time;
    logic [5:0]  r_s1_ant;
    // stage 2: qualify and map read
    logic        r_s2_valid, r_s2_last;
    logic [15:0] r_s2_dt;
    logic [6:0]  r_s2_n;
    logic [16:0] r_s2_long, r_s2_short;
    logic        r_s2_range;

    logic        s1_ok;
    logic [12:0] s1_addr;
    logic        walk_end;

    assign o_busy = (r_state != ST_IDLE);
    assign walk_end = (r_idx == r_total);
    assign s1_ok = r_s1_valid && (r_strict ? (r_st > r_s1_time) : (r_st >= r_s1_time));
    assign s1_addr = 13'(r_bio) * 13'(r_antigen_cnt) + 13'(r_s1_ant);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_gain <= '0;
            r_short_gain <= '0;
            r_wane_rate <= '0;
            r_sen_rate <= '0;
            r_strict <= 1'b0;
            r_antigen_cnt <= 7'(abws_pkg::NumAntigens);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                abws_pkg::CFG_LONG_GAIN:   r_long_gain <= i_cfg_data;
                abws_pkg::CFG_SHORT_GAIN:  r_short_gain <= i_cfg_data;
                abws_pkg::CFG_WANE_RATE:   r_wane_rate <= i_cfg_data[15:0];
                abws_pkg::CFG_SEN_RATE:    r_sen_rate <= i_cfg_data[15:0];
                abws_pkg::CFG_STRICT:      r_strict <= i_cfg_data[0];
                abws_pkg::CFG_ANTIGEN_CNT: r_antigen_cnt <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy && abws_pkg::t_opcode'(i_opcode) == abws_pkg::OP_APPEND
            && r_total < ExpCntW'(abws_pkg::MaxExposures)) begin
            r_exp_time[r_total[ExpIdxW-1:0]] <= i_exposure_time;
            r_exp_ant[r_total[ExpIdxW-1:0]]  <= i_exposure_antigen;
        end
        r_s1_time <= r_exp_time[r_idx[ExpIdxW-1:0]];
        r_s1_ant  <= r_exp_ant[r_idx[ExpIdxW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy && abws_pkg::t_opcode'(i_opcode) == abws_pkg::OP_MAPWR
            && 32'(i_map_address) < 32'(abws_pkg::MapDepth)) begin
            r_long_map[i_map_address[MapAddrW-1:0]]  <= i_map_long_value;
            r_short_map[i_map_address[MapAddrW-1:0]] <= i_map_short_value;
        end
        r_s2_long  <= r_long_map[s1_addr[MapAddrW-1:0]];
        r_s2_short <= r_short_map[s1_addr[MapAddrW-1:0]];
    end

    abws_pkg::t_tok c_tok [5];
    logic [47:0] c_a [5];
    logic [47:0] c_b [5];
    logic [47:0] c_c [5];

    always_comb begin
        c_tok[0].valid     = r_s2_valid;
        c_tok[0].dt        = r_s2_dt;
        c_tok[0].long_val  = r_s2_range ? r_s2_long : 17'd0;
        c_tok[0].short_val = r_s2_range ? r_s2_short : 17'd0;
        c_tok[0].n         = r_s2_n;
        c_tok[0].last      = r_s2_last;
        c_a[0] = '0;
        c_b[0] = '0;
        c_c[0] = '0;
    end

    for (genvar g = 0; g < 4; g++) begin : g_cell
        abws_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_kind(3'(g)),
            .i_long_gain(r_long_gain), .i_short_gain(r_short_gain),
            .i_wane_rate(r_wane_rate), .i_sen_rate(r_sen_rate),
            .i_tok(c_tok[g]), .i_a(c_a[g]), .i_b(c_b[g]), .i_c(c_c[g]),
            .o_tok(c_tok[g+1]), .o_a(c_a[g+1]), .o_b(c_b[g+1]), .o_c(c_c[g+1])
        );
    end

    logic signed [33:0] acc_sum;
    assign acc_sum = r_acc + $signed({1'b0, c_a[4][48-1:16]} > 33'h0ffffffff
                     ? 34'h0ffffffff : 34'({1'b0, c_a[4][48-1:16]}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_total <= '0;
            r_idx <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            o_valid <= 1'b0;
            r_n <= '0;
        end else begin
            o_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_valid <= s1_ok;
            r_s2_last <= r_s1_last;
            r_s2_dt <= r_st - r_s1_time;
            r_s2_n <= r_n + 7'd1;
            r_s2_range <= 32'(s1_addr) < 32'(abws_pkg::MapDepth);
            if (s1_ok) begin
                r_n <= r_n + 7'd1;
            end
            if (c_tok[4].valid) begin
                r_acc <= acc_sum > 34'sh07fffffff ? 34'sh07fffffff : acc_sum;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        case (abws_pkg::t_opcode'(i_opcode))
                            abws_pkg::OP_CLEAR: r_total <= '0;
                            abws_pkg::OP_APPEND: begin
                                if (r_total < ExpCntW'(abws_pkg::MaxExposures)) begin
                                    r_total <= r_total + 1'b1;
                                end
                            end
                            abws_pkg::OP_QUERY: begin
                                r_state <= ST_WALK;
                                r_idx <= '0;
                                r_st <= i_sample_time;
                                r_bio <= i_biomarker_index;
                                r_acc <= 34'(i_base_level);
                                r_n <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WALK: begin
                    if (walk_end) begin
                        r_state <= ST_DRAIN;
                        r_idx <= '0;
                    end else begin
                        r_s1_valid <= 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == ExpCntW'(6)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                    o_valid <= 1'b1;
                    o_predicted_level <= r_acc < -34'sh080000000 ? 32'sh80000000
                                         : r_acc[31:0];
                    o_infections_counted <= r_n;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
